>>> src/quantile_contour_point_check_unit_assert.svh
// Assertion macros for the quantile contour point check unit.
// Used by the top level only; depends on nothing else.
`ifndef QUANTILE_CONTOUR_POINT_CHECK_UNIT_ASSERT_SVH
`define QUANTILE_CONTOUR_POINT_CHECK_UNIT_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QCPC_ASSERT_IMPL(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define QCPC_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> src/qcpc_pkg.sv
// Shared types, constants and fixed-point helpers of the point check unit.
// Used by all modules; depends on nothing.
package qcpc_pkg;
  localparam int MaxDirections = 16;
  localparam int MaxPredictors = 4;
  localparam int ValueWidth    = 32;
  localparam int CoefsPerDir   = 16;
  localparam int DirW   = $clog2(MaxDirections);
  localparam int AddrW  = DirW + 4;
  localparam int QDepth = 2;

  localparam logic [2:0] CfgNumDirections = 3'd0;
  localparam logic [2:0] CfgUseSplines    = 3'd1;
  localparam logic [2:0] CfgNumPredictors = 3'd2;
  localparam logic [2:0] CfgCov0          = 3'd3;
  localparam logic [2:0] CfgCov1          = 3'd4;
  localparam logic [2:0] CfgCov2          = 3'd5;
  localparam logic [2:0] CfgCov3          = 3'd6;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTest = 1'b1;

  typedef logic signed [ValueWidth-1:0] val_t;

  // One queued command from the front part to the back part.
  typedef struct packed {
    logic             is_test;
    logic [AddrW-1:0] addr;
    logic             addr_ok;
    logic [31:0]      value;
    logic [31:0]      px;
    logic [31:0]      py;
    logic [31:0]      pz;
  } cmd_t;

  function automatic val_t sat_ext(input logic signed [63:0] x);
    logic signed [63:0] vmax;
    logic signed [63:0] vmin;
    vmax = 64'sd1 <<< (ValueWidth - 1);
    vmax = vmax - 64'sd1;
    vmin = -vmax - 64'sd1;
    if (x > vmax) return val_t'(vmax);
    if (x < vmin) return val_t'(vmin);
    return val_t'(x);
  endfunction

  function automatic val_t from32(input logic [31:0] v);
    return sat_ext(64'(signed'(v)));
  endfunction

  // Product already formed; floor shift by 16 then saturate.
  function automatic val_t qscale(input logic signed [2*ValueWidth-1:0] p);
    logic signed [2*ValueWidth-1:0] s;
    logic signed [63:0] vmax;
    logic signed [2*ValueWidth-1:0] hi;
    logic signed [2*ValueWidth-1:0] lo;
    s = p >>> 16;
    vmax = (64'sd1 <<< (ValueWidth - 1)) - 64'sd1;
    hi = (2*ValueWidth)'(vmax);
    lo = -hi - 1;
    if (s > hi) return val_t'(hi);
    if (s < lo) return val_t'(lo);
    return val_t'(s);
  endfunction

  function automatic val_t qadd(input val_t a, input val_t b);
    return sat_ext(64'(a) + 64'(b));
  endfunction
endpackage

>>> src/qcpc_front.sv
// Front part: takes input beats and pushes classified commands into a queue.
// Depends on qcpc_pkg.
module qcpc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [3:0]           dir_index,
  input  logic [3:0]           coef_select,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  output logic                 q_valid,
  input  logic                 q_pop,
  output qcpc_pkg::cmd_t       q_head
);
  localparam int PtrW = $clog2(qcpc_pkg::QDepth);
  qcpc_pkg::cmd_t q_mem [qcpc_pkg::QDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [PtrW:0]   count;
  logic            push;
  qcpc_pkg::cmd_t  cmd;

  assign in_ready = (count != (PtrW+1)'(qcpc_pkg::QDepth));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign q_head   = q_mem[rd_ptr];

  always_comb begin
    cmd.is_test = (req_type == qcpc_pkg::ReqTest);
    cmd.addr    = {dir_index[qcpc_pkg::DirW-1:0], coef_select};
    cmd.addr_ok = ({1'b0, dir_index} < 5'(qcpc_pkg::MaxDirections));
    cmd.value   = coef_value;
    cmd.px      = point_x;
    cmd.py      = point_y;
    cmd.pz      = point_z;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr] <= cmd;
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (q_pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PtrW+1)'(push) - (PtrW+1)'(q_pop);
    end
  end
endmodule

>>> src/qcpc_back.sv
// Back part: owns the coefficient memory and evaluates one direction at a time.
// Depends on qcpc_pkg.
module qcpc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  qcpc_pkg::cmd_t       q_head,
  input  logic [4:0]           num_directions,
  input  logic                 use_splines,
  input  logic [2:0]           num_predictors,
  input  logic [31:0]          cov [qcpc_pkg::MaxPredictors],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   kept_x,
  output logic signed [31:0]   kept_y,
  output logic signed [31:0]   kept_z,
  output logic                 busy
);
  localparam int VW = qcpc_pkg::ValueWidth;
  typedef enum logic [2:0] {S_IDLE, S_READ, S_MUL, S_SUM, S_CMP, S_OUT} state_t;

  logic [31:0] mem [qcpc_pkg::MaxDirections * qcpc_pkg::CoefsPerDir];
  state_t state;
  logic [qcpc_pkg::DirW:0] dir;
  logic [qcpc_pkg::DirW:0] nd;
  logic [2:0]  np;
  logic [3:0]  coef_idx;
  logic [31:0] rdata;
  logic [4:0]  rcnt;
  qcpc_pkg::val_t c [16];
  qcpc_pkg::val_t p [3];
  qcpc_pkg::val_t prod;
  qcpc_pkg::val_t left;
  qcpc_pkg::val_t right;
  qcpc_pkg::val_t d1;
  qcpc_pkg::val_t d2;
  logic [3:0]  step;
  logic [31:0] px, py, pz;
  logic signed [2*VW-1:0] mul_a;
  logic signed [2*VW-1:0] mul_b;
  qcpc_pkg::val_t ma, mb;

  assign q_pop = q_valid && (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign busy = (state != S_IDLE);
  assign kept_x = px;
  assign kept_y = py;
  assign kept_z = pz;

  // Operand selection for the shared multiplier, one product per step.
  always_comb begin
    ma = '0;
    mb = '0;
    case (step)
      4'd0:  begin ma = c[0];  mb = p[0]; end
      4'd1:  begin ma = c[1];  mb = p[1]; end
      4'd2:  begin ma = c[2];  mb = p[2]; end
      4'd3:  begin ma = c[3];  mb = p[0]; end
      4'd4:  begin ma = c[4];  mb = p[1]; end
      4'd5:  begin ma = c[5];  mb = p[2]; end
      4'd6:  begin ma = c[6];  mb = p[0]; end
      4'd7:  begin ma = c[7];  mb = p[1]; end
      4'd8:  begin ma = c[8];  mb = p[2]; end
      4'd9:  begin ma = c[9];  mb = d1; end
      4'd10: begin ma = c[10]; mb = d2; end
      4'd11: begin ma = qcpc_pkg::from32(cov[0]); mb = c[12]; end
      4'd12: begin ma = qcpc_pkg::from32(cov[1]); mb = c[13]; end
      4'd13: begin ma = qcpc_pkg::from32(cov[2]); mb = c[14]; end
      4'd14: begin ma = qcpc_pkg::from32(cov[3]); mb = c[15]; end
      default: begin ma = '0; mb = '0; end
    endcase
    mul_a = (2*VW)'(ma);
    mul_b = (2*VW)'(mb);
  end

  always_ff @(posedge clk) begin
    if (q_pop && !q_head.is_test && q_head.addr_ok) mem[q_head.addr] <= q_head.value;
    rdata <= mem[{dir[qcpc_pkg::DirW-1:0], coef_idx}];
    prod  <= qcpc_pkg::qscale(mul_a * mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_pop && q_head.is_test) begin
            px <= q_head.px;
            py <= q_head.py;
            pz <= q_head.pz;
            p[0] <= qcpc_pkg::from32(q_head.px);
            p[1] <= qcpc_pkg::from32(q_head.py);
            p[2] <= qcpc_pkg::from32(q_head.pz);
            nd <= (num_directions > 5'(qcpc_pkg::MaxDirections)) ?
                  (qcpc_pkg::DirW+1)'(qcpc_pkg::MaxDirections) :
                  (qcpc_pkg::DirW+1)'(num_directions);
            np <= (num_predictors > 3'(qcpc_pkg::MaxPredictors)) ?
                  3'(qcpc_pkg::MaxPredictors) : num_predictors;
            dir <= '0;
            coef_idx <= '0;
            rcnt <= '0;
            if (num_directions != '0) state <= S_READ;
          end
        end
        // Stream the 16 coefficients of one direction, one read a cycle.
        S_READ: begin
          coef_idx <= coef_idx + 4'd1;
          rcnt <= rcnt + 5'd1;
          if (rcnt != '0) c[4'(rcnt - 5'd1)] <= qcpc_pkg::from32(rdata);
          if (rcnt == 5'd16) begin
            step <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_SUM;
        end
        S_SUM: begin
          case (step)
            4'd0: left <= prod;
            4'd1, 4'd2: left <= qcpc_pkg::qadd(left, prod);
            4'd3: d1 <= prod;
            4'd4, 4'd5: d1 <= qcpc_pkg::qadd(d1, prod);
            4'd6: d2 <= prod;
            4'd7, 4'd8: d2 <= qcpc_pkg::qadd(d2, prod);
            4'd9: right <= prod;
            4'd10: right <= qcpc_pkg::qadd(right, prod);
            default: begin
              if ({1'b0, step} - 5'd11 < {2'b0, np}) right <= qcpc_pkg::qadd(right, prod);
            end
          endcase
          if (step == 4'd14) begin
            state <= S_CMP;
          end else begin
            step <= step + 4'd1;
            state <= S_MUL;
          end
        end
        S_CMP: begin
          if (left < (use_splines ? qcpc_pkg::qadd(right, c[11]) : right)) begin
            state <= S_IDLE;
          end else if (dir + 1'b1 == nd) begin
            state <= S_OUT;
          end else begin
            dir <= dir + 1'b1;
            coef_idx <= '0;
            rcnt <= '0;
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/quantile_contour_point_check_unit.sv
// Top level of the quantile contour point check unit.
// Depends on qcpc_pkg, qcpc_front, qcpc_back and the assertion macro header.
//
// Input beats (in_valid/in_ready) are either coefficient loads or point tests.
// The front part queues up to two beats, so input is still taken, until the
// queue is full, while the back part works or the output stalls. A load is
// written to the coefficient memory as the back part pops it. A test reads
// each direction's 16 coefficients from the memory read port and then runs
// 15 products through one shared multiplier, each with a multiply and a sum
// state, plus a compare; directions run in turn. A kept point is shown on
// out_valid and held until out_ready; the back part waits meanwhile while
// the queue still fills. Rejected points and tests with zero directions give
// no output beat. Reset empties the queue and restores the register
// defaults; the coefficient memory is not cleared and must be loaded before
// use. Configuration beats (cfg_valid/cfg_ready) are always accepted.
module quantile_contour_point_check_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 req_type,
  input  logic [3:0]           dir_index,
  input  logic [3:0]           coef_select,
  input  logic signed [31:0]   coef_value,
  input  logic signed [31:0]   point_x,
  input  logic signed [31:0]   point_y,
  input  logic signed [31:0]   point_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   kept_x,
  output logic signed [31:0]   kept_y,
  output logic signed [31:0]   kept_z,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data
);
  `include "quantile_contour_point_check_unit_assert.svh"

  logic [4:0]  num_directions;
  logic        use_splines;
  logic [2:0]  num_predictors;
  logic [31:0] cov [qcpc_pkg::MaxPredictors];
  logic        q_valid;
  logic        q_pop;
  logic        busy;
  qcpc_pkg::cmd_t q_head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_directions <= 5'd16;
      use_splines    <= 1'b0;
      num_predictors <= 3'd1;
      for (int i = 0; i < qcpc_pkg::MaxPredictors; i++) cov[i] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        qcpc_pkg::CfgNumDirections: num_directions <= cfg_data[4:0];
        qcpc_pkg::CfgUseSplines:    use_splines    <= cfg_data[0];
        qcpc_pkg::CfgNumPredictors: num_predictors <= cfg_data[2:0];
        qcpc_pkg::CfgCov0:          cov[0] <= cfg_data;
        qcpc_pkg::CfgCov1:          cov[1] <= cfg_data;
        qcpc_pkg::CfgCov2:          cov[2] <= cfg_data;
        qcpc_pkg::CfgCov3:          cov[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  qcpc_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .dir_index, .coef_select,
    .coef_value, .point_x, .point_y, .point_z, .q_valid, .q_pop, .q_head
  );

  qcpc_back u_back (
    .clk, .rst, .q_valid, .q_pop, .q_head, .num_directions, .use_splines,
    .num_predictors, .cov, .out_valid, .out_ready, .kept_x, .kept_y, .kept_z,
    .busy
  );

  `QCPC_ASSERT_IMPL(a_pop_needs_item, clk, rst, q_pop, q_valid, "pop from empty queue")
  `QCPC_ASSERT_IMPL(a_no_pop_while_busy, clk, rst, busy, !q_pop, "pop while back part busy")
  `QCPC_ASSERT_NEXT(a_out_holds, clk, rst, out_valid && !out_ready,
                    out_valid && $stable(kept_x), "result dropped while stalled")
endmodule

>>> test/quantile_contour_point_check_unit_checker.sv
// Checker for the quantile contour point check unit: watches all three channels,
// predicts kept points and compares each output beat. Depends on qcpc_pkg.
module quantile_contour_point_check_unit_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               req_type,
  input  logic [3:0]         dir_index,
  input  logic [3:0]         coef_select,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] kept_x,
  input  logic signed [31:0] kept_y,
  input  logic signed [31:0] kept_z,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output int                 kept_pending,
  output int                 fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } point_t;

  logic signed [31:0] coef_mem [qcpc_pkg::MaxDirections*qcpc_pkg::CoefsPerDir];
  logic [4:0]         n_dirs;
  logic               splines_on;
  logic [2:0]         n_preds;
  logic signed [31:0] covariate [4];
  point_t             kept_q [$];

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  function automatic longint clamp32(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // Operands are 32 bits, so the exact product fits in 64 bits; >>> floors.
  function automatic longint fx_mul(input longint a, input longint b);
    return clamp32((a * b) >>> 16);
  endfunction

  function automatic longint fx_add(input longint a, input longint b);
    return clamp32(a + b);
  endfunction

  function automatic longint coef_at(input int d, input int sel);
    return longint'(coef_mem[d*qcpc_pkg::CoefsPerDir + sel]);
  endfunction

  function automatic longint proj3(input int d, input int base, input point_t p);
    longint s;
    s = fx_mul(coef_at(d, base), longint'(p.x));
    s = fx_add(s, fx_mul(coef_at(d, base + 1), longint'(p.y)));
    s = fx_add(s, fx_mul(coef_at(d, base + 2), longint'(p.z)));
    return s;
  endfunction

  function automatic bit point_survives(input point_t p);
    int     nd;
    int     np;
    longint lhs;
    longint rhs;
    nd = (n_dirs > qcpc_pkg::MaxDirections) ? qcpc_pkg::MaxDirections : int'(n_dirs);
    np = (n_preds > qcpc_pkg::MaxPredictors) ? qcpc_pkg::MaxPredictors : int'(n_preds);
    if (nd == 0) return 1'b0;
    for (int d = 0; d < nd; d++) begin
      lhs = proj3(d, 0, p);
      rhs = fx_mul(coef_at(d, 9), proj3(d, 3, p));
      rhs = fx_add(rhs, fx_mul(coef_at(d, 10), proj3(d, 6, p)));
      for (int i = 0; i < np; i++) begin
        rhs = fx_add(rhs, fx_mul(longint'(covariate[i]), coef_at(d, 12 + i)));
      end
      if (splines_on) rhs = fx_add(rhs, coef_at(d, 11));
      if (lhs < rhs) return 1'b0;
    end
    return 1'b1;
  endfunction

  initial fail_count = 0;
  initial kept_pending = 0;

  always @(posedge clk) begin
    point_t p;
    point_t want;
    if (rst) begin
      n_dirs     <= 5'd16;
      splines_on <= 1'b0;
      n_preds    <= 3'd1;
      for (int i = 0; i < 4; i++) covariate[i] <= '0;
      kept_q.delete();
      kept_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          qcpc_pkg::CfgNumDirections: n_dirs <= cfg_data[4:0];
          qcpc_pkg::CfgUseSplines:    splines_on <= cfg_data[0];
          qcpc_pkg::CfgNumPredictors: n_preds <= cfg_data[2:0];
          qcpc_pkg::CfgCov0:          covariate[0] <= cfg_data;
          qcpc_pkg::CfgCov1:          covariate[1] <= cfg_data;
          qcpc_pkg::CfgCov2:          covariate[2] <= cfg_data;
          qcpc_pkg::CfgCov3:          covariate[3] <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (req_type == qcpc_pkg::ReqLoad) begin
          coef_mem[int'(dir_index)*qcpc_pkg::CoefsPerDir + int'(coef_select)] = coef_value;
        end else begin
          p = '{point_x, point_y, point_z};
          if (point_survives(p)) kept_q.push_back(p);
        end
      end
      if (out_valid && out_ready) begin
        if (kept_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("unexpected output beat: got %0d %0d %0d", kept_x, kept_y, kept_z);
        end else begin
          want = kept_q.pop_front();
          if (want.x !== kept_x || want.y !== kept_y || want.z !== kept_z) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("kept point mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                       want.x, want.y, want.z, kept_x, kept_y, kept_z);
          end
        end
      end
      kept_pending <= kept_q.size();
    end
  end
endmodule

>>> test/quantile_contour_point_check_unit_tb.sv
// Testbench top for the quantile contour point check unit: clock, reset, stimulus
// and verdict. Depends on qcpc_pkg, the unit and its checker.
module quantile_contour_point_check_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               req_type = qcpc_pkg::ReqLoad;
  logic [3:0]         dir_index = '0;
  logic [3:0]         coef_select = '0;
  logic signed [31:0] coef_value = '0;
  logic signed [31:0] point_x = '0;
  logic signed [31:0] point_y = '0;
  logic signed [31:0] point_z = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] kept_x;
  logic signed [31:0] kept_y;
  logic signed [31:0] kept_z;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  int                 kept_pending;
  int                 fail_count;

  bit quiet = 1'b0;
  int hold_cycles = 0;
  int idle_count = 0;

  localparam int SettleCycles = 2500;
  localparam int WatchdogLimit = 20000;
  localparam logic signed [31:0] QMaxV = 32'sh7fffffff;
  localparam logic signed [31:0] QMinV = 32'sh80000000;

  quantile_contour_point_check_unit dut (.*);

  quantile_contour_point_check_unit_checker chk (.*);

  initial forever #4 clk = ~clk;

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(0, 10);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: too long without any beat on any channel.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_count <= 0;
    end else if (idle_count >= WatchdogLimit) begin
      $display("quantile_contour_point_check_unit_tb: FAIL");
      $finish;
    end else begin
      idle_count <= idle_count + 1;
    end
  end

  task automatic send_beat(input logic rt, input logic [3:0] di, input logic [3:0] cs,
                           input logic [31:0] cv, input logic [31:0] px,
                           input logic [31:0] py, input logic [31:0] pz);
    in_valid    <= 1'b1;
    req_type    <= rt;
    dir_index   <= di;
    coef_select <= cs;
    coef_value  <= cv;
    point_x     <= px;
    point_y     <= py;
    point_z     <= pz;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic load_coef(input int d, input int sel, input logic [31:0] v);
    send_beat(qcpc_pkg::ReqLoad, 4'(d), 4'(sel), v, $urandom, $urandom, $urandom);
  endtask

  task automatic test_point(input logic [31:0] px, input logic [31:0] py,
                            input logic [31:0] pz);
    send_beat(qcpc_pkg::ReqTest, 4'($urandom), 4'($urandom), $urandom, px, py, pz);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Drain: all kept points seen, then room for rejected tests still in flight.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (kept_pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Values that tend to let points through: zero directions and weights,
  // negative add term, small estimates.
  function automatic logic [31:0] lenient_coef(input int sel);
    if (sel < 3 || sel == 9 || sel == 10) return ($urandom_range(0, 3) == 0) ? 32'($urandom_range(0, 4096)) : 32'd0;
    if (sel == 11) return -32'($urandom_range(0, 1 << 20));
    if (sel >= 12) return ($urandom_range(0, 1) == 0) ? 32'd0 : 32'($urandom_range(0, 512)) - 32'd256;
    return $urandom;
  endfunction

  function automatic logic [31:0] coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
  endfunction

  task automatic random_items(input int count);
    int sel;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        sel = $urandom_range(0, 15);
        load_coef($urandom_range(0, 15), sel,
                  ($urandom_range(0, 9) < 6) ? lenient_coef(sel) : $urandom);
      end else begin
        test_point(coord(), coord(), coord());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole table before any test reads it.
    for (int d = 0; d < qcpc_pkg::MaxDirections; d++)
      for (int s = 0; s < qcpc_pkg::CoefsPerDir; s++)
        load_coef(d, s, (s == 11) ? -32'sd65536 : ((s < 3 || s == 9 || s == 10 || s >= 12) ? 32'd0 : $urandom));

    // Directed: coordinate extremes, then saturating products in direction 0.
    test_point(QMaxV, QMaxV, QMaxV);
    test_point(QMinV, QMinV, QMinV);
    test_point(32'd0, 32'd0, 32'd0);
    test_point(32'hffffffff, 32'd1, 32'hffffffff);
    load_coef(0, 0, QMaxV);
    load_coef(0, 1, QMinV);
    load_coef(0, 2, 32'hffffffff);
    load_coef(0, 9, QMinV);
    load_coef(0, 3, QMaxV);
    load_coef(0, 11, QMaxV);
    test_point(QMaxV, QMinV, 32'd1);
    test_point(QMinV, QMaxV, 32'hffffffff);
    test_point(32'd65536, 32'd0, QMinV);
    load_coef(0, 0, 32'd0);
    load_coef(0, 1, 32'd0);
    load_coef(0, 2, 32'd0);
    load_coef(0, 9, 32'd0);
    load_coef(0, 11, 32'hffff0000);
    test_point(QMaxV, QMinV, 32'd1);
    random_items(200);
    drain();

    // Out-of-range counts, splines on, covariate extremes.
    write_reg(qcpc_pkg::CfgNumDirections, 32'd31);
    write_reg(qcpc_pkg::CfgUseSplines, 32'hffffffff);
    write_reg(qcpc_pkg::CfgNumPredictors, 32'd7);
    write_reg(qcpc_pkg::CfgCov0, QMaxV);
    write_reg(qcpc_pkg::CfgCov1, QMinV);
    write_reg(qcpc_pkg::CfgCov2, 32'd0);
    write_reg(qcpc_pkg::CfgCov3, 32'hffffffff);
    random_items(180);
    drain();

    // No directions in use: tests give nothing.
    write_reg(qcpc_pkg::CfgNumDirections, 32'd0);
    write_reg(qcpc_pkg::CfgNumPredictors, 32'd0);
    random_items(50);
    drain();

    // One direction, no covariates, and a long output hold-off.
    write_reg(qcpc_pkg::CfgNumDirections, 32'd1);
    write_reg(qcpc_pkg::CfgUseSplines, 32'd0);
    for (int s = 0; s < qcpc_pkg::CoefsPerDir; s++) load_coef(0, s, lenient_coef(s));
    hold_cycles = 3000;
    random_items(220);
    drain();

    write_reg(qcpc_pkg::CfgNumDirections, 32'd2);
    write_reg(qcpc_pkg::CfgUseSplines, 32'd1);
    write_reg(qcpc_pkg::CfgNumPredictors, 32'd4);
    write_reg(qcpc_pkg::CfgCov0, $urandom);
    write_reg(qcpc_pkg::CfgCov1, 32'($urandom_range(0, 1 << 17)));
    write_reg(qcpc_pkg::CfgCov2, $urandom);
    write_reg(qcpc_pkg::CfgCov3, 32'($urandom_range(0, 1 << 17)));
    random_items(220);
    drain();

    // Final stretch runs without any idling on either side.
    write_reg(qcpc_pkg::CfgNumDirections, 32'd3);
    write_reg(qcpc_pkg::CfgNumPredictors, 32'd2);
    quiet = 1'b1;
    random_items(200);
    drain();

    if (fail_count == 0 && kept_pending == 0) begin
      $display("quantile_contour_point_check_unit_tb: PASS");
    end else begin
      $display("quantile_contour_point_check_unit_tb: FAIL");
    end
    $finish;
  end
endmodule
